/* hw/rtl/rcr_pkg.sv */
// shared types, constants and the sine table for the column renderer
package rcr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FOV   = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

    // register reset values
    localparam logic [14:0] FOV_RESET   = 15'd8192;
    localparam logic [16:0] LIMIT_RESET = 17'd65536;
    localparam logic [11:0] STEP_RESET  = 12'd41;

    // glyph codes
    localparam logic [15:0] GLYPH_SPACE = 16'h0020;
    localparam logic [15:0] GLYPH_FULL  = 16'h2588;
    localparam logic [15:0] GLYPH_DARK  = 16'h2593;
    localparam logic [15:0] GLYPH_MED   = 16'h2592;
    localparam logic [15:0] GLYPH_LIGHT = 16'h2591;
    localparam logic [15:0] GLYPH_HASH  = 16'h0023;
    localparam logic [15:0] GLYPH_X     = 16'h0078;
    localparam logic [15:0] GLYPH_DOT   = 16'h002E;
    localparam logic [15:0] GLYPH_DASH  = 16'h002D;

    // divider sizing for the ceiling divide
    localparam int DIV_NUM_W = 23;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_CNT_W = 5;

    // quarter-wave sine, Q1.14, 1/128 turn per entry
    localparam logic [14:0] QSIN [33] = '{
        15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,
        15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,
        15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
        15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679, 15'd15893,
        15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
    };

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic spread;
        logic angle;
        logic trig;
        logic premul;
        logic march;
        logic corr;
        logic ceil;
        logic fin;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic march_done;
        logic emit_done;
    } t_sts;

    // interpolated sine of a 16-bit angle
    function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
        logic [14:0] p;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [14:0] lo;
        logic [9:0]  diff;
        logic [18:0] prod;
        logic [14:0] v;
        p = {1'b0, a[13:0]};
        if (a[14]) begin
            p = 15'h4000 - p;
        end
        idx  = p[14:9];
        frac = p[8:0];
        lo   = 15'd0;
        diff = 10'd0;
        prod = 19'd0;
        if (idx >= 6'd32) begin
            v = 15'd16384;
        end else begin
            lo   = QSIN[idx];
            diff = 10'(QSIN[idx + 6'd1] - lo);
            prod = 19'(diff) * 19'(frac);
            v    = lo + 15'(prod[18:9]);
        end
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

/* hw/rtl/rcr_div.sv */
// restoring divider, one quotient bit per cycle
module rcr_div
    import rcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quo
);
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   n_shift;
    logic                 n_bit;

    // trial subtract
    always_comb begin
        n_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        n_bit   = n_shift >= {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != '0;
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], n_bit};
            r_rem <= n_bit ? DIV_DEN_W'(n_shift - {1'b0, r_den}) : n_shift[DIV_DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

/* hw/rtl/rcr_ctrl.sv */
// sequencer for one column: angle, march, distance, rows
module rcr_ctrl
    import rcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SPREAD   = 4'd1;
    localparam logic [3:0] S_SPREAD_W = 4'd2;
    localparam logic [3:0] S_ANGLE    = 4'd3;
    localparam logic [3:0] S_TRIG     = 4'd4;
    localparam logic [3:0] S_PREMUL   = 4'd5;
    localparam logic [3:0] S_MARCH    = 4'd6;
    localparam logic [3:0] S_CORR     = 4'd7;
    localparam logic [3:0] S_CEIL     = 4'd8;
    localparam logic [3:0] S_CEIL_W   = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_SPREAD;
            end
            S_SPREAD: begin
                o_cmd.spread = 1'b1;
                n_state      = S_SPREAD_W;
            end
            S_SPREAD_W: begin
                if (!i_sts.div_busy) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = S_TRIG;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state    = S_PREMUL;
            end
            S_PREMUL: begin
                o_cmd.premul = 1'b1;
                n_state      = S_MARCH;
            end
            S_MARCH: begin
                o_cmd.march = 1'b1;
                if (i_sts.march_done) n_state = S_CORR;
            end
            S_CORR: begin
                o_cmd.corr = 1'b1;
                n_state    = S_CEIL;
            end
            S_CEIL: begin
                o_cmd.ceil = 1'b1;
                n_state    = S_CEIL_W;
            end
            S_CEIL_W: begin
                if (!i_sts.div_busy) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;
endmodule

/* hw/rtl/rcr_dp.sv */
// datapath: registers, trig, march accumulators, ceiling and row output
module rcr_dp
    import rcr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 120,
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAP_SIZE      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic [15:0] i_player_x,
    input  logic [15:0] i_player_y,
    input  logic [15:0] i_heading,
    input  logic [6:0]  i_column,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [5:0]  o_out_row,
    output logic [15:0] o_out_glyph,
    output logic        o_out_last
);
    localparam logic [23:0] H24      = 24'(SCREEN_HEIGHT);
    localparam logic [23:0] HK       = 24'(SCREEN_HEIGHT * 8192);
    localparam logic [11:0] H12      = 12'(SCREEN_HEIGHT);
    localparam logic [5:0]  ROW_LAST = 6'(SCREEN_HEIGHT - 1);
    localparam logic [19:0] MAP_LIM  = 20'(MAP_SIZE * 4096);
    localparam logic [3:0]  CELL_END = 4'(MAP_SIZE - 1);
    // reciprocal of the screen width, exact for any 22-bit column product
    localparam int          SPREAD_K = 22 + $clog2(SCREEN_WIDTH);
    localparam logic [22:0] SPREAD_M = 23'(((64'd1 << SPREAD_K) + 64'(SCREEN_WIDTH) - 64'd1)
                                           / 64'(SCREEN_WIDTH));

    // configuration
    logic [14:0] r_fov;
    logic [16:0] r_limit;
    logic [11:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov   <= FOV_RESET;
            r_limit <= LIMIT_RESET;
            r_step  <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOV:   r_fov   <= i_cfg_data[14:0];
                CFG_LIMIT: r_limit <= i_cfg_data;
                CFG_STEP:  r_step  <= i_cfg_data[11:0];
                default:   ;
            endcase
        end
    end

    logic [15:0]        r_px, r_py, r_head;
    logic [6:0]         r_col;
    logic [21:0]        r_sprod;
    logic [15:0]        r_ray, r_off;
    logic signed [15:0] r_sx, r_sy, r_co;
    logic signed [32:0] r_stepx, r_stepy, r_ax, r_ay;
    logic [16:0]        r_dist;
    logic               r_mdone;
    logic [16:0]        r_corr;
    logic signed [6:0]  r_ceil;
    logic               r_cdiv;
    logic signed [7:0]  r_floor;
    logic [15:0]        r_shade;
    logic [5:0]         r_row;

    // ceiling divider
    logic                 div_start, div_busy;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;

    logic [11:0] eff_step;
    logic [23:0] hc, num_pos, num_neg;
    logic        ceil_pos;
    logic [17:0] twoc;
    logic [44:0] spread_prod;
    logic [15:0] spread_val;

    always_comb begin
        eff_step    = (r_step == '0) ? 12'd1 : r_step;
        hc          = H24 * {7'd0, r_corr};
        ceil_pos    = hc >= HK;
        num_pos     = hc - HK;
        num_neg     = HK - hc;
        twoc        = {r_corr, 1'b0};
        div_start   = i_cmd.ceil && r_corr != '0 && ceil_pos;
        div_num     = num_pos[DIV_NUM_W-1:0];
        div_den     = twoc;
        // column spread by reciprocal multiply
        spread_prod = 45'(r_sprod) * 45'(SPREAD_M);
        spread_val  = 16'(spread_prod >> SPREAD_K);
    end

    rcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // ray point test
    logic signed [19:0] rx, ry;
    logic               out_x, out_y, wall, outside, blocked;

    always_comb begin
        rx      = $signed({4'd0, r_px}) + 20'(r_ax >>> 14);
        ry      = $signed({4'd0, r_py}) + 20'(r_ay >>> 14);
        out_x   = rx[19] || ($unsigned(rx) >= MAP_LIM);
        out_y   = ry[19] || ($unsigned(ry) >= MAP_LIM);
        outside = out_x || out_y;
        wall    = rx[15:12] == 4'd0 || ry[15:12] == 4'd0 ||
                  rx[15:12] == CELL_END || ry[15:12] == CELL_END;
        blocked = outside || wall;
    end

    // ceiling after the divide, floor row and wall shade
    logic signed [6:0] eff_ceil;
    logic [18:0]       c1, c2, c3, c4;
    logic [31:0]       corr_prod;

    always_comb begin
        eff_ceil  = r_cdiv ? $signed(div_quo[6:0]) : r_ceil;
        c1        = {2'd0, r_corr};
        c2        = {1'b0, r_corr, 1'b0};
        c3        = c1 + c2;
        c4        = {r_corr, 2'b00};
        corr_prod = 32'(r_dist) * 32'(r_co[14:0]);
    end

    // per-column work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_player_x;
            r_py   <= i_player_y;
            r_head <= i_heading;
            r_col  <= i_column;
        end
        if (i_cmd.spread) begin
            r_sprod <= 22'(r_col) * 22'(r_fov);
        end
        if (i_cmd.angle) begin
            r_ray <= r_head - {2'd0, r_fov[14:1]} + spread_val;
            r_off <= {2'd0, r_fov[14:1]} - spread_val;
        end
        if (i_cmd.trig) begin
            r_sx <= sine_q14(r_ray);
            r_sy <= sine_q14(r_ray + 16'h4000);
            r_co <= sine_q14(r_off + 16'h4000);
        end
        if (i_cmd.premul) begin
            r_stepx <= 33'(r_sx * $signed({1'b0, eff_step}));
            r_stepy <= 33'(r_sy * $signed({1'b0, eff_step}));
            r_ax    <= 33'(r_sx * $signed({1'b0, eff_step}));
            r_ay    <= 33'(r_sy * $signed({1'b0, eff_step}));
            r_dist  <= (r_limit == '0) ? 17'd0 : 17'(eff_step);
        end else if (i_cmd.march && !r_mdone) begin
            if (blocked) begin
                if (outside) r_dist <= r_limit;
            end else if (r_dist < r_limit) begin
                r_dist <= r_dist + 17'(eff_step);
                r_ax   <= r_ax + r_stepx;
                r_ay   <= r_ay + r_stepy;
            end
        end
        if (i_cmd.corr) begin
            r_corr <= (r_co > 16'sd0) ? corr_prod[30:14] : 17'd0;
        end
        if (i_cmd.ceil) begin
            r_cdiv <= r_corr != '0 && ceil_pos;
            if (r_corr == '0) begin
                r_ceil <= -7'sd1;
            end else if (!ceil_pos) begin
                r_ceil <= (num_neg < {6'd0, twoc}) ? 7'sd0 : -7'sd1;
            end
        end
        if (i_cmd.fin) begin
            r_ceil  <= eff_ceil;
            r_cdiv  <= 1'b0;
            r_floor <= 8'(SCREEN_HEIGHT) - 8'(eff_ceil);
            if (c4 <= {2'd0, r_limit})      r_shade <= GLYPH_FULL;
            else if (c3 <= {2'd0, r_limit}) r_shade <= GLYPH_DARK;
            else if (c2 <= {2'd0, r_limit}) r_shade <= GLYPH_MED;
            else if (c1 <= {2'd0, r_limit}) r_shade <= GLYPH_LIGHT;
            else                            r_shade <= GLYPH_SPACE;
        end
    end

    // march stop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mdone <= 1'b0;
        end else if (i_cmd.premul) begin
            r_mdone <= r_limit == '0;
        end else if (i_cmd.march && !r_mdone) begin
            r_mdone <= blocked || r_dist >= r_limit;
        end
    end

    // glyph of the current row
    logic [11:0] rr;
    logic [15:0] glyph;
    logic        load;

    always_comb begin
        rr = H12 - {6'd0, r_row};
        if ($signed({2'b00, r_row}) <= 8'(r_ceil)) begin
            glyph = GLYPH_SPACE;
        end else if ($signed({2'b00, r_row}) <= r_floor) begin
            glyph = r_shade;
        end else if ((rr << 3) < H12) begin
            glyph = GLYPH_HASH;
        end else if ((rr << 2) < H12) begin
            glyph = GLYPH_X;
        end else if ((rr << 3) < 12'(3 * H12)) begin
            glyph = GLYPH_DOT;
        end else if (12'(rr * 12'd20) < 12'(9 * H12)) begin
            glyph = GLYPH_DASH;
        end else begin
            glyph = GLYPH_SPACE;
        end
        load = i_cmd.emit && (!o_out_valid || !i_out_stall);
    end

    // output register, freed by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_row <= '0;
        end else if (load) begin
            r_row <= r_row + 1'b1;
        end
        if (load) begin
            o_out_row   <= r_row;
            o_out_glyph <= glyph;
            o_out_last  <= r_row == ROW_LAST;
        end
    end

    assign o_sts.div_busy   = div_busy;
    assign o_sts.march_done = r_mdone;
    assign o_sts.emit_done  = load && r_row == ROW_LAST;
endmodule

/* hw/rtl/raycast_column_renderer.sv */
// an accepted column runs through spread, angle, trig and the march, n = march steps
// (at most draw_limit/march_step + 1), then distance correction and the ceiling divide,
// skipped when the ceiling needs no divide, then one row per cycle while not stalled
// one column in flight at a time, its pace set by the one-point-per-cycle march loop and,
// when needed, one pass through the bit-serial ceiling divider
// reset: configuration registers take their default values, control returns to idle, no output valid
module raycast_column_renderer
    import rcr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 120,
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAP_SIZE      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_player_x,
    input  logic [15:0] i_player_y,
    input  logic [15:0] i_heading,
    input  logic [6:0]  i_column,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_out_row,
    output logic [15:0] o_out_glyph,
    output logic        o_out_last
);
    t_cmd cmd;
    t_sts sts;

    // sequencer
    rcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    rcr_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_SIZE      (MAP_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_player_x  (i_player_x),
        .i_player_y  (i_player_y),
        .i_heading   (i_heading),
        .i_column    (i_column),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_row   (o_out_row),
        .o_out_glyph (o_out_glyph),
        .o_out_last  (o_out_last)
    );

    // one column in flight at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a column is in flight");

    // last marks the bottom row only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_last) |-> (o_out_row == 6'(SCREEN_HEIGHT - 1)))
        else $error("last flag on a row other than the bottom");

    // rows follow one another without gaps
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_last)
        |=> (o_out_valid && o_out_row == $past(o_out_row) + 6'd1))
        else $error("row sequence broken");
endmodule
